// File: sv/lom_pkg.sv
// Package for the limit order matcher: command and status codes, FSM states.
// No dependencies.
package lom_pkg;

  localparam int DefaultBookDepth = 32;

  localparam logic [1:0] CMD_BUY    = 2'd0;
  localparam logic [1:0] CMD_SELL   = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic [2:0] ST_RESTED    = 3'd0;
  localparam logic [2:0] ST_FILLED    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_NOTFOUND  = 3'd4;
  localparam logic [2:0] ST_ZERO      = 3'd5;

  // one book entry: price, quantity, owner, handle
  typedef struct packed {
    logic [30:0] price;
    logic [31:0] qty;
    logic [15:0] owner;
    logic [15:0] handle;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MREAD, S_MWAIT, S_MATCH, S_TRADE,
    S_SHIFT_RD, S_SHIFT_WAIT, S_SHIFT_WR,
    S_FIND_RD, S_FIND_WAIT, S_INS_RD, S_INS_WAIT, S_STATUS
  } state_t;

endpackage

// File: sv/limit_order_matcher.sv
// Top level of the limit order matcher: control sequencer over two book memories.
// Depends on lom_pkg and lom_book.
//
// Usage: commands enter on the in_ valid/ready channel; results leave on the
// out_ valid/ready channel through a single output register. A command is taken
// only when the previous one has fully finished (one command at a time).
// A new order walks the best opposite entries: each trade reads the memory,
// waits, compares and reports, plus a shift of the side when an entry empties
// (read, wait, write per moved entry). Resting a remainder scans for the slot
// (read, compare per entry) and shifts the tail. Cancel searches the bids then
// the asks (read, compare per entry), then shifts. Cost is set by the single
// read port of each side's memory. A command ends with exactly one status result
// (last = 1); command 3 gives none. With the receiver stalled the sequencer
// holds on the pending result. Reset empties both sides (counts to zero) and
// restarts handles at zero; the memory contents need no clearing.
module limit_order_matcher #(
  parameter int BOOK_DEPTH = lom_pkg::DefaultBookDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_user_id,
  input  logic [31:0] in_quantity,
  input  logic [30:0] in_price,
  input  logic [15:0] in_order_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [15:0] out_handle,
  output logic [15:0] out_seller_id,
  output logic [15:0] out_buyer_id,
  output logic [30:0] out_trade_price,
  output logic [31:0] out_trade_quantity,
  output logic [2:0]  out_status,
  output logic        out_last
);
  import lom_pkg::*;

  localparam int AW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(BOOK_DEPTH);

  state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r [2];
  logic [CW-1:0] cnt_nxt [2];
  logic [15:0] next_handle_r, next_handle_nxt;

  // latched command
  logic [1:0]  cmd_r, cmd_nxt;
  logic [15:0] user_r, user_nxt;
  logic [31:0] qty_r, qty_nxt;
  logic [30:0] price_r, price_nxt;
  logic [15:0] hdl_r, hdl_nxt;
  logic        side_r, side_nxt;       // side under work: 0 bids, 1 asks
  logic [CW-1:0] idx_r, idx_nxt;       // scan/shift index
  logic        shift_up_r, shift_up_nxt; // 1: insert (move towards tail)
  logic [CW-1:0] stop_r, stop_nxt;     // shift end position
  entry_t      head_r, head_nxt;       // working copy of best entry
  logic [2:0]  stat_r, stat_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic        ok_r, ok_nxt, ol_r, ol_nxt;
  logic [15:0] oh_r, oh_nxt, os_r, os_nxt, ob_r, ob_nxt;
  logic [30:0] op_r, op_nxt;
  logic [31:0] oq_r, oq_nxt;
  logic [2:0]  ost_r, ost_nxt;

  // memory ports
  logic        we [2];
  logic [AW-1:0] waddr [2];
  logic [AW-1:0] raddr [2];
  entry_t      wdata [2];
  entry_t      rdata [2];

  for (genvar s = 0; s < 2; s++) begin : g_side
    lom_book #(.Depth(BOOK_DEPTH)) u_book (
      .clk(clk), .we(we[s]), .waddr(waddr[s]), .wdata(wdata[s]),
      .raddr(raddr[s]), .rdata(rdata[s])
    );
  end

  logic out_free;
  logic crosses;
  logic [31:0] fill;
  entry_t rd;
  logic [CW-1:0] cnt_side;

  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign rd = side_r ? rdata[1] : rdata[0];
  assign cnt_side = side_r ? cnt_r[1] : cnt_r[0];
  assign fill = (qty_r < head_r.qty) ? qty_r : head_r.qty;
  // buy (side asks) crosses when ask <= price, sell when bid >= price
  assign crosses = side_r ? (head_r.price <= price_r) : (head_r.price >= price_r);

  // state register and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      next_handle_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r[0] <= cnt_nxt[0];
      cnt_r[1] <= cnt_nxt[1];
      next_handle_r <= next_handle_nxt;
      ov_r <= ov_nxt;
    end
    cmd_r <= cmd_nxt; user_r <= user_nxt; qty_r <= qty_nxt; price_r <= price_nxt;
    hdl_r <= hdl_nxt; side_r <= side_nxt; idx_r <= idx_nxt; shift_up_r <= shift_up_nxt;
    stop_r <= stop_nxt; head_r <= head_nxt; stat_r <= stat_nxt;
    ok_r <= ok_nxt; ol_r <= ol_nxt; oh_r <= oh_nxt; os_r <= os_nxt; ob_r <= ob_nxt;
    op_r <= op_nxt; oq_r <= oq_nxt; ost_r <= ost_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt[0] = cnt_r[0]; cnt_nxt[1] = cnt_r[1];
    next_handle_nxt = next_handle_r;
    cmd_nxt = cmd_r; user_nxt = user_r; qty_nxt = qty_r; price_nxt = price_r;
    hdl_nxt = hdl_r; side_nxt = side_r; idx_nxt = idx_r; shift_up_nxt = shift_up_r;
    stop_nxt = stop_r; head_nxt = head_r; stat_nxt = stat_r;
    ov_nxt = ov_r && !out_ready;
    ok_nxt = ok_r; ol_nxt = ol_r; oh_nxt = oh_r; os_nxt = os_r; ob_nxt = ob_r;
    op_nxt = op_r; oq_nxt = oq_r; ost_nxt = ost_r;
    for (int s = 0; s < 2; s++) begin
      we[s] = 1'b0;
      waddr[s] = idx_r[AW-1:0];
      wdata[s] = head_r;
      raddr[s] = idx_r[AW-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_nxt = in_command; user_nxt = in_user_id; qty_nxt = in_quantity;
          price_nxt = in_price; hdl_nxt = in_order_handle;
          idx_nxt = '0;
          priority if (in_command == CMD_CANCEL) begin
            side_nxt = 1'b0;
            state_nxt = S_FIND_RD;
          end else if (in_command == CMD_BUY || in_command == CMD_SELL) begin
            if (in_quantity == '0) begin
              hdl_nxt = '0;
              stat_nxt = ST_ZERO;
              state_nxt = S_STATUS;
            end else begin
              hdl_nxt = next_handle_r;
              next_handle_nxt = next_handle_r + 16'd1;
              side_nxt = (in_command == CMD_BUY);
              state_nxt = S_MREAD;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      // read the best opposite entry; finish when filled, rest when that side is empty
      S_MREAD: begin
        raddr[side_r] = '0;
        if (qty_r == '0) begin
          stat_nxt = ST_FILLED;
          state_nxt = S_STATUS;
        end else if (cnt_side == '0) begin
          side_nxt = !side_r; idx_nxt = '0;
          state_nxt = S_INS_RD;
        end else begin
          idx_nxt = '0;
          state_nxt = S_MWAIT;
        end
      end
      S_MWAIT: begin
        head_nxt = rd;
        state_nxt = S_MATCH;
      end
      S_MATCH: begin
        if (crosses) state_nxt = S_TRADE;
        else begin
          side_nxt = !side_r; idx_nxt = '0;
          state_nxt = S_INS_RD;
        end
      end
      // report one trade and update the head entry
      S_TRADE: begin
        if (out_free) begin
          ov_nxt = 1'b1; ok_nxt = 1'b0; ol_nxt = 1'b0; ost_nxt = ST_RESTED;
          oh_nxt = hdl_r; oq_nxt = fill;
          if (side_r) begin
            os_nxt = head_r.owner; ob_nxt = user_r; op_nxt = price_r;
          end else begin
            os_nxt = user_r; ob_nxt = head_r.owner; op_nxt = head_r.price;
          end
          qty_nxt = qty_r - fill;
          head_nxt.qty = head_r.qty - fill;
          if (head_r.qty == fill) begin
            // remove the head: shift tail down
            shift_up_nxt = 1'b0; idx_nxt = '0;
            stop_nxt = cnt_side - CW'(1);
            if (side_r) cnt_nxt[1] = cnt_r[1] - CW'(1);
            else cnt_nxt[0] = cnt_r[0] - CW'(1);
            state_nxt = S_SHIFT_RD;
          end else begin
            we[side_r] = 1'b1; waddr[side_r] = '0;
            wdata[side_r] = head_r; wdata[side_r].qty = head_r.qty - fill;
            state_nxt = S_MREAD;
          end
        end
      end

      // remove: entry[idx] <= entry[idx+1] until stop; insert: walk downwards
      S_SHIFT_RD: begin
        if (shift_up_r) begin
          if (idx_r == stop_r) begin
            we[side_r] = 1'b1; waddr[side_r] = stop_r[AW-1:0];
            wdata[side_r] = head_r;
            state_nxt = S_STATUS;
          end else begin
            raddr[side_r] = AW'(idx_r - CW'(1));
            state_nxt = S_SHIFT_WAIT;
          end
        end else begin
          if (idx_r >= stop_r) state_nxt = (cmd_r == CMD_CANCEL) ? S_STATUS : S_MREAD;
          else begin
            raddr[side_r] = AW'(idx_r + CW'(1));
            state_nxt = S_SHIFT_WAIT;
          end
        end
      end
      // keep the neighbour address so the read data holds into the write cycle
      S_SHIFT_WAIT: begin
        raddr[side_r] = shift_up_r ? AW'(idx_r - CW'(1)) : AW'(idx_r + CW'(1));
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        we[side_r] = 1'b1; waddr[side_r] = idx_r[AW-1:0]; wdata[side_r] = rd;
        idx_nxt = shift_up_r ? idx_r - CW'(1) : idx_r + CW'(1);
        state_nxt = S_SHIFT_RD;
      end

      // cancel search, bids first then asks
      S_FIND_RD: begin
        if (idx_r >= cnt_side) begin
          if (side_r) begin
            stat_nxt = ST_NOTFOUND;
            state_nxt = S_STATUS;
          end else begin
            side_nxt = 1'b1; idx_nxt = '0;
          end
        end else state_nxt = S_FIND_WAIT;
      end
      S_FIND_WAIT: begin
        if (rd.handle == hdl_r) begin
          stat_nxt = ST_CANCELLED;
          shift_up_nxt = 1'b0;
          stop_nxt = cnt_side - CW'(1);
          if (side_r) cnt_nxt[1] = cnt_r[1] - CW'(1);
          else cnt_nxt[0] = cnt_r[0] - CW'(1);
          state_nxt = S_SHIFT_RD;
        end else begin
          idx_nxt = idx_r + CW'(1);
          state_nxt = S_FIND_RD;
        end
      end

      // find the insert slot in own side
      S_INS_RD: begin
        if (cnt_side == FULL) begin
          stat_nxt = ST_FULL;
          state_nxt = S_STATUS;
        end else if (idx_r >= cnt_side) begin
          head_nxt = '{price: price_r, qty: qty_r, owner: user_r, handle: hdl_r};
          stat_nxt = ST_RESTED;
          shift_up_nxt = 1'b1; stop_nxt = idx_r; idx_nxt = cnt_side;
          if (side_r) cnt_nxt[1] = cnt_r[1] + CW'(1);
          else cnt_nxt[0] = cnt_r[0] + CW'(1);
          state_nxt = S_SHIFT_RD;
        end else state_nxt = S_INS_WAIT;
      end
      S_INS_WAIT: begin
        if (side_r ? (rd.price <= price_r) : (rd.price >= price_r)) begin
          idx_nxt = idx_r + CW'(1);
          state_nxt = S_INS_RD;
        end else begin
          head_nxt = '{price: price_r, qty: qty_r, owner: user_r, handle: hdl_r};
          stat_nxt = ST_RESTED;
          shift_up_nxt = 1'b1; stop_nxt = idx_r; idx_nxt = cnt_side;
          if (side_r) cnt_nxt[1] = cnt_r[1] + CW'(1);
          else cnt_nxt[0] = cnt_r[0] + CW'(1);
          state_nxt = S_SHIFT_RD;
        end
      end

      // final status transaction
      S_STATUS: begin
        if (out_free) begin
          ov_nxt = 1'b1; ok_nxt = 1'b1; ol_nxt = 1'b1;
          oh_nxt = hdl_r; os_nxt = '0; ob_nxt = '0; op_nxt = '0; oq_nxt = '0;
          ost_nxt = stat_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_handle = oh_r;
  assign out_seller_id = os_r;
  assign out_buyer_id = ob_r;
  assign out_trade_price = op_r;
  assign out_trade_quantity = oq_r;
  assign out_status = ost_r;
  assign out_last = ol_r;

  // checks
  a_cnt_bid: assert property (@(posedge clk) disable iff (!rst_n) cnt_r[0] <= FULL)
    else $error("bid count beyond depth");
  a_cnt_ask: assert property (@(posedge clk) disable iff (!rst_n) cnt_r[1] <= FULL)
    else $error("ask count beyond depth");
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> out_last == out_kind)
    else $error("last flag disagrees with kind");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && in_ready |-> state_r == S_IDLE)
    else $error("command taken while busy");
endmodule

// File: sv/lom_book.sv
// One side of the book: entry memory with one write and one registered read port.
// Depends on lom_pkg.
module lom_book #(
  parameter int Depth = lom_pkg::DefaultBookDepth
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  lom_pkg::entry_t          wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output lom_pkg::entry_t          rdata
);
  import lom_pkg::*;

  entry_t mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
